/* sv/kcde_pkg.sv */
package kcde_pkg;

  localparam int unsigned Digits   = 4;
  localparam int unsigned DigitW   = 4;
  localparam int unsigned IdxW     = 2;
  localparam int unsigned KeyW     = 3;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned HoldW    = 16;
  localparam int unsigned ValueW   = 14;
  localparam int unsigned ActW     = 3;

  typedef logic [Digits-1:0][DigitW-1:0] digits_t;
  typedef logic [IdxW-1:0]               idx_t;

  localparam digits_t         InitDigits = {4'd4, 4'd3, 4'd2, 4'd1};
  localparam idx_t            InitIndex  = idx_t'(3);
  localparam logic [HoldW-1:0] HoldReset = 16'd50;
  localparam logic [DigitW-1:0] DigitMax = 4'd9;
  localparam idx_t            LastIndex  = idx_t'(Digits - 1);

  localparam logic [KeyW-1:0] CHORD_A   = 3'b001;
  localparam logic [KeyW-1:0] CHORD_AB  = 3'b011;
  localparam logic [KeyW-1:0] CHORD_ABC = 3'b111;

  typedef enum logic [ActW-1:0] {
    ACT_NONE    = 3'd0,
    ACT_SELECT  = 3'd1,
    ACT_PLUS    = 3'd2,
    ACT_MINUS   = 3'd3,
    ACT_UNKNOWN = 3'd4
  } action_e;

  typedef struct packed {
    logic [KeyW-1:0]  key_bits;
    logic [TimeW-1:0] now_ms;
  } samp_t;

  typedef struct packed {
    logic [ValueW-1:0] edit_value;
    idx_t              selected_digit;
    logic [Digits-1:0] blink_mask;
    logic [ActW-1:0]   action_taken;
  } res_t;

  function automatic logic [ValueW-1:0] digits_to_bin(input digits_t d);
    logic [ValueW-1:0] acc;
    acc = ValueW'(d[0]) * ValueW'(1000)
        + ValueW'(d[1]) * ValueW'(100)
        + ValueW'(d[2]) * ValueW'(10)
        + ValueW'(d[3]);
    return acc;
  endfunction

endpackage

/* sv/kcde_chan_if.sv */
interface kcde_samp_if;
  import kcde_pkg::*;
  logic  valid;
  logic  ready;
  samp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface kcde_res_if;
  import kcde_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* sv/key_chord_digit_editor.sv */
// The result is registered: an accepted item passes the input register, then the
// result register, and a stall on the result side can hold it there.
// Throughput: one item per cycle while the result side is not stalled; the update
// path is a 32-bit subtract and compare plus a single digit step, with no iteration.
// Reset (rst_ni low, asynchronous): value 1234, ones digit selected, hold
// 50 ms, no press pending, both pipeline registers empty.
module key_chord_digit_editor (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [kcde_pkg::HoldW-1:0]     cfg_wdata_i,
  kcde_samp_if.sink                      samp_i,
  kcde_res_if.source                     res_o
);
  import kcde_pkg::*;

  logic               s1_vld_q;
  samp_t              s1_q;
  logic               adv;

  logic [HoldW-1:0]   hold_q;
  logic [KeyW-1:0]    chord_q, chord_d;
  logic               press_q, press_d;
  logic               wait_q, wait_d;
  logic [TimeW-1:0]   rtime_q, rtime_d;
  digits_t            digits_q, digits_d;
  idx_t               idx_q, idx_d;
  action_e            act;
  logic [TimeW-1:0]   elapsed;
  logic [DigitW-1:0]  cur;

  logic               out_vld_q;
  res_t               out_q;

  assign adv          = s1_vld_q && (!out_vld_q || res_o.ready);
  assign samp_i.ready = !s1_vld_q || adv;
  assign res_o.valid  = out_vld_q;
  assign res_o.data   = out_q;
  assign elapsed      = s1_q.now_ms - rtime_q;
  assign cur          = digits_q[idx_q];

  always_comb begin
    chord_d  = chord_q;
    press_d  = press_q;
    wait_d   = wait_q;
    rtime_d  = rtime_q;
    digits_d = digits_q;
    idx_d    = idx_q;
    act      = ACT_NONE;
    if (s1_q.key_bits != '0) begin
      chord_d = chord_q | s1_q.key_bits;
      press_d = 1'b1;
      wait_d  = 1'b0;
    end else if (press_q) begin
      if (!wait_q) begin
        wait_d  = 1'b1;
        rtime_d = s1_q.now_ms;
      end else if (elapsed >= TimeW'(hold_q)) begin
        case (chord_q)
          CHORD_A: begin
            act   = ACT_SELECT;
            idx_d = (idx_q == LastIndex) ? '0 : idx_q + idx_t'(1);
          end
          CHORD_AB: begin
            act             = ACT_PLUS;
            digits_d[idx_q] = (cur >= DigitMax) ? '0 : cur + DigitW'(1);
          end
          CHORD_ABC: begin
            act             = ACT_MINUS;
            digits_d[idx_q] = (cur == '0) ? DigitMax : cur - DigitW'(1);
          end
          default: begin
            act = ACT_UNKNOWN;
          end
        endcase
        chord_d = '0;
        press_d = 1'b0;
        wait_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= HoldReset;
    end else if (cfg_we_i) begin
      hold_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (samp_i.ready) begin
      s1_vld_q <= samp_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (samp_i.ready && samp_i.valid) begin
      s1_q <= samp_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chord_q   <= '0;
      press_q   <= 1'b0;
      wait_q    <= 1'b0;
      rtime_q   <= '0;
      digits_q  <= InitDigits;
      idx_q     <= InitIndex;
      out_vld_q <= 1'b0;
    end else begin
      if (adv) begin
        chord_q  <= chord_d;
        press_q  <= press_d;
        wait_q   <= wait_d;
        rtime_q  <= rtime_d;
        digits_q <= digits_d;
        idx_q    <= idx_d;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.edit_value     <= digits_to_bin(digits_d);
      out_q.selected_digit <= idx_d;
      out_q.blink_mask     <= Digits'(1) << idx_d;
      out_q.action_taken   <= act;
    end
  end

endmodule

/* sv/kcde_checker.sv */
module kcde_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [kcde_pkg::ValueW-1:0]   edit_value_i,
  input logic [kcde_pkg::IdxW-1:0]     selected_digit_i,
  input logic [kcde_pkg::Digits-1:0]   blink_mask_i
);
  import kcde_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(edit_value_i)
      && $stable(selected_digit_i) && $stable(blink_mask_i))
    else $error("result changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> blink_mask_i == (Digits'(1) << selected_digit_i))
    else $error("blink mask does not match selected digit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> edit_value_i <= ValueW'(9999))
    else $error("edit value out of decimal range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with empty result register");

endmodule

bind key_chord_digit_editor kcde_checker u_kcde_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_i       (samp_i.ready),
  .out_valid_i      (res_o.valid),
  .out_ready_i      (res_o.ready),
  .edit_value_i     (res_o.data.edit_value),
  .selected_digit_i (res_o.data.selected_digit),
  .blink_mask_i     (res_o.data.blink_mask)
);

/* sim/kcde_display_check.sv */
`timescale 1ns / 100ps

module kcde_display_check
  import kcde_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [HoldW-1:0] cfg_wdata_i,
  kcde_samp_if             samp_i,
  kcde_res_if              res_i,
  output int               error_count_o
);

  logic [KeyW-1:0]   chord_acc;
  logic              key_down;
  logic              release_armed;
  logic [TimeW-1:0]  release_ms;
  logic [HoldW-1:0]  hold_ms;
  logic [DigitW-1:0] digit_val [Digits];
  idx_t              cursor;
  res_t              display_q [$];

  task automatic predict_display(input samp_t s, output res_t r);
    action_e          act;
    logic [TimeW-1:0] elapsed;
    int unsigned      val;
    act = ACT_NONE;
    if (s.key_bits != '0) begin
      chord_acc     = chord_acc | s.key_bits;
      key_down      = 1'b1;
      release_armed = 1'b0;
    end else if (key_down) begin
      elapsed = s.now_ms - release_ms;
      if (!release_armed) begin
        release_armed = 1'b1;
        release_ms    = s.now_ms;
      end else if (elapsed >= TimeW'(hold_ms)) begin
        case (chord_acc)
          CHORD_A: begin
            cursor = (cursor == idx_t'(Digits - 1)) ? '0 : cursor + idx_t'(1);
            act    = ACT_SELECT;
          end
          CHORD_AB: begin
            digit_val[cursor] = (digit_val[cursor] >= 4'd9) ? '0
                              : digit_val[cursor] + DigitW'(1);
            act = ACT_PLUS;
          end
          CHORD_ABC: begin
            digit_val[cursor] = (digit_val[cursor] == '0) ? 4'd9
                              : digit_val[cursor] - DigitW'(1);
            act = ACT_MINUS;
          end
          default: act = ACT_UNKNOWN;
        endcase
        chord_acc     = '0;
        key_down      = 1'b0;
        release_armed = 1'b0;
      end
    end
    val = 0;
    for (int i = 0; i < Digits; i++) val = val * 10 + 32'(digit_val[i]);
    r.edit_value     = ValueW'(val);
    r.selected_digit = cursor;
    r.blink_mask     = '0;
    r.blink_mask[cursor] = 1'b1;
    r.action_taken   = act;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track_proc
    res_t want;
    res_t got;
    if (!rst_ni) begin
      chord_acc     = '0;
      key_down      = 1'b0;
      release_armed = 1'b0;
      release_ms    = '0;
      hold_ms       = HoldReset;
      cursor        = idx_t'(3);
      for (int i = 0; i < Digits; i++) digit_val[i] = DigitW'(i + 1);
      display_q.delete();
      error_count_o = 0;
    end else begin
      if (cfg_we_i) hold_ms = cfg_wdata_i;
      if (res_i.valid && res_i.ready) begin
        got = res_i.data;
        if (display_q.size() == 0) begin
          $error("display item arrived with nothing expected");
          error_count_o++;
        end else begin
          want = display_q.pop_front();
          if (got.edit_value !== want.edit_value) begin
            $error("edit_value: expected %0d, got %0d", want.edit_value, got.edit_value);
            error_count_o++;
          end
          if (got.selected_digit !== want.selected_digit) begin
            $error("selected_digit: expected %0d, got %0d",
                   want.selected_digit, got.selected_digit);
            error_count_o++;
          end
          if (got.blink_mask !== want.blink_mask) begin
            $error("blink_mask: expected %b, got %b", want.blink_mask, got.blink_mask);
            error_count_o++;
          end
          if (got.action_taken !== want.action_taken) begin
            $error("action_taken: expected %0d, got %0d",
                   want.action_taken, got.action_taken);
            error_count_o++;
          end
        end
      end
      if (samp_i.valid && samp_i.ready) begin
        predict_display(samp_i.data, want);
        display_q.push_back(want);
      end
    end
  end

endmodule

/* sim/key_chord_digit_editor_tb.sv */
`timescale 1ns / 100ps

module key_chord_digit_editor_tb;
  import kcde_pkg::*;

  localparam logic [KeyW-1:0] NoKeys = '0;

  logic             clk_i  = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i;
  logic [HoldW-1:0] cfg_wdata_i;
  int               error_count;
  bit               idle_on        = 1'b1;
  bit               long_stall_req = 1'b0;
  int unsigned      accepted_samples  = 0;
  int unsigned      returned_displays = 0;
  int unsigned      hold_now = HoldReset;
  logic [TimeW-1:0] wall_ms;

  kcde_samp_if sample_ch ();
  kcde_res_if  display_ch ();

  key_chord_digit_editor u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .samp_i      (sample_ch),
    .res_o       (display_ch)
  );

  kcde_display_check u_display_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .samp_i        (sample_ch),
    .res_i         (display_ch),
    .error_count_o (error_count)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk_i) begin
    if (display_ch.valid && display_ch.ready) returned_displays++;
  end

  initial begin
    display_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        display_ch.ready <= 1'b0;
        repeat (47) @(posedge clk_i);
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        display_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 7)) @(posedge clk_i);
      end else begin
        display_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic [KeyW-1:0] keys, input logic [TimeW-1:0] ms);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      sample_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.data  <= '{key_bits: keys, now_ms: ms};
    @(posedge clk_i);
    while (!sample_ch.ready) @(posedge clk_i);
    accepted_samples++;
  endtask

  task automatic pause_until_drained();
    sample_ch.valid <= 1'b0;
    do @(posedge clk_i); while (returned_displays != accepted_samples);
  endtask

  task automatic set_hold(input logic [HoldW-1:0] v);
    pause_until_drained();
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    hold_now = v;
  endtask

  // press in pieces, maybe bounce, release, sample short of the hold, then once the hold has passed
  task automatic play_chord(input logic [KeyW-1:0] chord);
    logic [TimeW-1:0] released;
    repeat ($urandom_range(0, 2)) begin
      wall_ms += $urandom_range(0, 40);
      send_item(chord & KeyW'($urandom), wall_ms);
    end
    wall_ms += $urandom_range(0, 40);
    send_item(chord, wall_ms);
    if ($urandom_range(0, 5) == 0) begin
      wall_ms += $urandom_range(1, 20);
      send_item(NoKeys, wall_ms);
      wall_ms += $urandom_range(1, 20);
      send_item(chord, wall_ms);
    end
    wall_ms += $urandom_range(0, 40);
    released = wall_ms;
    send_item(NoKeys, released);
    if (hold_now != 0) begin
      repeat ($urandom_range(0, 2)) send_item(NoKeys, released + $urandom_range(0, hold_now - 1));
    end
    if ($urandom_range(0, 2) == 0) wall_ms = released + hold_now;
    else wall_ms = released + hold_now + $urandom_range(0, 100);
    send_item(NoKeys, wall_ms);
  endtask

  task automatic random_phase(input int unsigned n_items);
    int unsigned      stop_at;
    int unsigned      pick;
    logic [KeyW-1:0]  other;
    stop_at = accepted_samples + n_items;
    wall_ms = $urandom;
    while (accepted_samples < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        send_item(KeyW'($urandom), $urandom);
      end else if (pick < 40) begin
        play_chord(CHORD_A);
      end else if (pick < 62) begin
        play_chord(CHORD_AB);
      end else if (pick < 84) begin
        play_chord(CHORD_ABC);
      end else begin
        do other = KeyW'($urandom);
        while (other == NoKeys || other == CHORD_A || other == CHORD_AB || other == CHORD_ABC);
        play_chord(other);
      end
    end
  endtask

  initial begin
    logic [TimeW-1:0] t0;
    sample_ch.valid <= 1'b0;
    sample_ch.data  <= '0;
    cfg_we_i        <= 1'b0;
    cfg_wdata_i     <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(NoKeys, '0);
    send_item(NoKeys, '1);
    t0 = 32'hFFFF_FFE0;
    send_item(CHORD_A, t0);
    send_item(NoKeys, t0 + 5);
    send_item(NoKeys, t0 + 54);
    send_item(NoKeys, t0 + 55);
    t0 = 32'h0000_1000;
    send_item(3'b001, t0);
    send_item(3'b010, t0 + 1);
    send_item(NoKeys, t0 + 2);
    send_item(NoKeys, t0 + 52);
    send_item(3'b100, t0 + 100);
    send_item(CHORD_AB, t0 + 101);
    send_item(NoKeys, t0 + 110);
    send_item(NoKeys, t0 + 170);
    send_item(3'b010, t0 + 200);
    send_item(NoKeys, t0 + 210);
    send_item(NoKeys, t0 + 260);
    send_item(CHORD_A, t0 + 300);
    send_item(NoKeys, t0 + 310);
    send_item(CHORD_A, t0 + 320);
    send_item(NoKeys, t0 + 330);
    send_item(NoKeys, t0 + 360);
    send_item(NoKeys, t0 + 380);
    send_item(CHORD_ABC, '1);
    send_item(NoKeys, '0);
    send_item(NoKeys, 32'd50);

    set_hold('0);
    t0 = 32'h8000_0000;
    send_item(CHORD_A, t0);
    send_item(NoKeys, t0);
    send_item(NoKeys, t0);
    random_phase(120);
    long_stall_req = 1'b1;
    random_phase(120);

    set_hold('1);
    random_phase(200);

    set_hold(16'd1);
    random_phase(100);
    pause_until_drained();
    random_phase(100);

    set_hold(HoldW'($urandom_range(2, 300)));
    random_phase(250);

    set_hold(HoldReset);
    random_phase(250);

    idle_on = 1'b0;
    set_hold(HoldW'($urandom_range(2, 400)));
    random_phase(300);

    pause_until_drained();
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
